[rtl/rpss_pkg.sv]
package rpss_pkg;

    localparam int SAMPLE_W = 12;
    localparam int SLOPE_W  = 20;
    localparam int TICK_W   = 8;
    localparam int SP_W     = 16;
    localparam int PHASE_W  = 3;
    localparam int CFG_AW   = 8;
    localparam int PROD_W   = SLOPE_W + TICK_W;

    localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_RAMP1 = 3'd1;
    localparam logic [PHASE_W-1:0] PH_RAMP2 = 3'd2;
    localparam logic [PHASE_W-1:0] PH_RAMP3 = 3'd3;
    localparam logic [PHASE_W-1:0] PH_HOLD  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_COOL  = 3'd5;

    localparam logic [CFG_AW-1:0] REG_RAMP_ONE_SLOPE   = 8'd0;
    localparam logic [CFG_AW-1:0] REG_RAMP_TWO_SLOPE   = 8'd1;
    localparam logic [CFG_AW-1:0] REG_RAMP_THREE_SLOPE = 8'd2;
    localparam logic [CFG_AW-1:0] REG_RAMP_ONE_TICKS   = 8'd3;
    localparam logic [CFG_AW-1:0] REG_RAMP_TWO_TICKS   = 8'd4;
    localparam logic [CFG_AW-1:0] REG_RAMP_THREE_TICKS = 8'd5;
    localparam logic [CFG_AW-1:0] REG_HOLD_TICKS       = 8'd6;
    localparam logic [CFG_AW-1:0] REG_COOL_TICKS       = 8'd7;

    localparam logic [SAMPLE_W-1:0] GLITCH_LIMIT = 12'd20;
    localparam logic [SP_W-1:0] BASE_ONE   = 16'd6400;
    localparam logic [SP_W-1:0] BASE_TWO   = 16'd38400;
    localparam logic [SP_W-1:0] BASE_THREE = 16'd46848;
    localparam logic [SP_W-1:0] PEAK_SP    = 16'd57600;
    localparam logic [SP_W-1:0] COOL_SP    = 16'd6400;
    localparam logic [SP_W-1:0] SP_MAX     = 16'hFFFF;

    localparam logic [SLOPE_W-1:0] RST_RAMP_ONE_SLOPE   = 20'd45511;
    localparam logic [SLOPE_W-1:0] RST_RAMP_TWO_SLOPE   = 20'd30037;
    localparam logic [SLOPE_W-1:0] RST_RAMP_THREE_SLOPE = 20'd76459;
    localparam logic [TICK_W-1:0] RST_RAMP_ONE_TICKS    = 8'd180;
    localparam logic [TICK_W-1:0] RST_RAMP_TWO_TICKS    = 8'd72;
    localparam logic [TICK_W-1:0] RST_RAMP_THREE_TICKS  = 8'd36;
    localparam logic [TICK_W-1:0] RST_HOLD_TICKS        = 8'd18;
    localparam logic [TICK_W-1:0] RST_COOL_TICKS        = 8'd180;

    typedef struct packed {
        logic [SLOPE_W-1:0] ramp_one_slope;
        logic [SLOPE_W-1:0] ramp_two_slope;
        logic [SLOPE_W-1:0] ramp_three_slope;
        logic [TICK_W-1:0]  ramp_one_ticks;
        logic [TICK_W-1:0]  ramp_two_ticks;
        logic [TICK_W-1:0]  ramp_three_ticks;
        logic [TICK_W-1:0]  hold_ticks;
        logic [TICK_W-1:0]  cool_ticks;
    } cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] previous_sample;
        logic [PHASE_W-1:0]  phase;
        logic [TICK_W-1:0]   tick;
        logic [SP_W-1:0]     setpoint;
    } prof_state_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] temp_sample;
        logic                start_req;
        logic                abort;
    } item_t;

endpackage

[rtl/rpss_cfg_regs.sv]
module rpss_cfg_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        wr_en,
    input  logic [rpss_pkg::CFG_AW-1:0] wr_addr,
    input  logic [rpss_pkg::SLOPE_W-1:0] wr_data,
    output rpss_pkg::cfg_t              cfg
);

    rpss_pkg::cfg_t cfg_reg;
    rpss_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (wr_addr)
                rpss_pkg::REG_RAMP_ONE_SLOPE:   cfg_next.ramp_one_slope   = wr_data;
                rpss_pkg::REG_RAMP_TWO_SLOPE:   cfg_next.ramp_two_slope   = wr_data;
                rpss_pkg::REG_RAMP_THREE_SLOPE: cfg_next.ramp_three_slope = wr_data;
                rpss_pkg::REG_RAMP_ONE_TICKS:
                    cfg_next.ramp_one_ticks = wr_data[rpss_pkg::TICK_W-1:0];
                rpss_pkg::REG_RAMP_TWO_TICKS:
                    cfg_next.ramp_two_ticks = wr_data[rpss_pkg::TICK_W-1:0];
                rpss_pkg::REG_RAMP_THREE_TICKS:
                    cfg_next.ramp_three_ticks = wr_data[rpss_pkg::TICK_W-1:0];
                rpss_pkg::REG_HOLD_TICKS:
                    cfg_next.hold_ticks = wr_data[rpss_pkg::TICK_W-1:0];
                rpss_pkg::REG_COOL_TICKS:
                    cfg_next.cool_ticks = wr_data[rpss_pkg::TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ramp_one_slope   <= rpss_pkg::RST_RAMP_ONE_SLOPE;
            cfg_reg.ramp_two_slope   <= rpss_pkg::RST_RAMP_TWO_SLOPE;
            cfg_reg.ramp_three_slope <= rpss_pkg::RST_RAMP_THREE_SLOPE;
            cfg_reg.ramp_one_ticks   <= rpss_pkg::RST_RAMP_ONE_TICKS;
            cfg_reg.ramp_two_ticks   <= rpss_pkg::RST_RAMP_TWO_TICKS;
            cfg_reg.ramp_three_ticks <= rpss_pkg::RST_RAMP_THREE_TICKS;
            cfg_reg.hold_ticks       <= rpss_pkg::RST_HOLD_TICKS;
            cfg_reg.cool_ticks       <= rpss_pkg::RST_COOL_TICKS;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/rpss_step.sv]
module rpss_step (
    input  rpss_pkg::cfg_t                cfg,
    input  rpss_pkg::prof_state_t         cur,
    input  rpss_pkg::item_t               item,
    output rpss_pkg::prof_state_t         nxt,
    output logic                          sample_ok,
    output logic                          done
);

    function automatic logic [rpss_pkg::TICK_W-1:0] phase_limit(
        input rpss_pkg::cfg_t c,
        input logic [rpss_pkg::PHASE_W-1:0] p
    );
        logic [rpss_pkg::TICK_W-1:0] lim;
        case (p)
            rpss_pkg::PH_RAMP1: lim = c.ramp_one_ticks;
            rpss_pkg::PH_RAMP2: lim = c.ramp_two_ticks;
            rpss_pkg::PH_RAMP3: lim = c.ramp_three_ticks;
            rpss_pkg::PH_HOLD:  lim = c.hold_ticks;
            default:            lim = c.cool_ticks;
        endcase
        return lim;
    endfunction

    logic [rpss_pkg::SAMPLE_W-1:0] diff;
    logic [rpss_pkg::PHASE_W-1:0]  ph;
    logic [rpss_pkg::TICK_W-1:0]   tk;
    logic [rpss_pkg::SP_W-1:0]     sp;
    logic                          dn;
    logic                          settled;
    logic [rpss_pkg::SLOPE_W-1:0]  slope;
    logic [rpss_pkg::SP_W-1:0]     base;
    logic [rpss_pkg::PROD_W-1:0]   prod;
    logic [rpss_pkg::PROD_W-8:0]   ramp_sum;
    logic [rpss_pkg::SP_W-1:0]     ramp_sp;

    always_comb begin
        diff = (item.temp_sample >= cur.previous_sample)
             ? item.temp_sample - cur.previous_sample
             : cur.previous_sample - item.temp_sample;
        sample_ok = (item.temp_sample != '0) && (diff <= rpss_pkg::GLITCH_LIMIT);
    end

    // Phase advance: after the first step the tick is zero, so further steps
    // only happen through phases whose limit is zero.
    always_comb begin
        ph = cur.phase;
        tk = cur.tick;
        sp = cur.setpoint;
        dn = 1'b0;
        settled = 1'b0;
        if (item.start_req && cur.phase == rpss_pkg::PH_IDLE) begin
            ph = rpss_pkg::PH_RAMP1;
            tk = '0;
            sp = '0;
        end
        if (sample_ok && ph != rpss_pkg::PH_IDLE) begin
            for (int i = 0; i < 6; i++) begin
                if (!dn && !settled) begin
                    if (tk >= phase_limit(cfg, ph)) begin
                        tk = '0;
                        if (ph >= rpss_pkg::PH_COOL) begin
                            ph = rpss_pkg::PH_IDLE;
                            sp = '0;
                            dn = 1'b1;
                        end else begin
                            ph = ph + 3'd1;
                            if (ph == rpss_pkg::PH_HOLD) begin
                                sp = rpss_pkg::PEAK_SP;
                            end else if (ph == rpss_pkg::PH_COOL) begin
                                sp = rpss_pkg::COOL_SP;
                            end
                        end
                    end else begin
                        settled = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        case (ph)
            rpss_pkg::PH_RAMP1: begin
                slope = cfg.ramp_one_slope;
                base  = rpss_pkg::BASE_ONE;
            end
            rpss_pkg::PH_RAMP2: begin
                slope = cfg.ramp_two_slope;
                base  = rpss_pkg::BASE_TWO;
            end
            default: begin
                slope = cfg.ramp_three_slope;
                base  = rpss_pkg::BASE_THREE;
            end
        endcase
        prod     = rpss_pkg::PROD_W'(slope) * rpss_pkg::PROD_W'(tk);
        ramp_sum = (rpss_pkg::PROD_W-7)'(base)
                 + (rpss_pkg::PROD_W-7)'(prod[rpss_pkg::PROD_W-1:8]);
        ramp_sp  = (ramp_sum > (rpss_pkg::PROD_W-7)'(rpss_pkg::SP_MAX))
                 ? rpss_pkg::SP_MAX : ramp_sum[rpss_pkg::SP_W-1:0];
    end

    always_comb begin
        nxt.previous_sample = item.temp_sample;
        done = 1'b0;
        if (item.abort) begin
            nxt.phase    = rpss_pkg::PH_IDLE;
            nxt.tick     = '0;
            nxt.setpoint = '0;
        end else begin
            nxt.phase    = ph;
            nxt.tick     = tk;
            nxt.setpoint = sp;
            done         = dn;
            if (sample_ok && ph != rpss_pkg::PH_IDLE && !dn) begin
                if (ph == rpss_pkg::PH_RAMP1 || ph == rpss_pkg::PH_RAMP2 ||
                    ph == rpss_pkg::PH_RAMP3) begin
                    nxt.setpoint = ramp_sp;
                end
                nxt.tick = tk + 8'd1;
            end
        end
    end

endmodule

[rtl/reflow_profile_setpoint_sequencer.sv]
// Channel  | Direction | Handshake          | Payload
// s_       | in        | s_tvalid/s_tready  | s_tdata: temp_sample, start_req, abort
// m_       | out       | m_tvalid/m_tready  | m_tdata: setpoint, phase, sample_ok; m_tlast
// cfg_     | in        | cfg_valid/cfg_ready| cfg_addr register index, cfg_data value
//
// One item per clock cycle is sustained while m_tready is high; an accepted item goes
// to the input register, then the result register; the block holds at most two items.
// A synchronous low aresetn clears the profile state, the handshake state and
// restores the register defaults. A stalled result holds its item; the input
// register takes at most one more item, then s_tready stays low until the
// result is taken.
module reflow_profile_setpoint_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [11:0] temp_sample, [12] start_req, [13] abort
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [15:0] setpoint, [18:16] phase, [19] sample_ok
    output logic        m_tlast,    // done_res
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [rpss_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [rpss_pkg::SLOPE_W-1:0] cfg_data
);

    rpss_pkg::cfg_t        cfg;
    rpss_pkg::item_t       in_item_reg;
    rpss_pkg::item_t       in_item_next;
    logic                  in_valid_reg;
    logic                  in_valid_next;
    rpss_pkg::prof_state_t state_reg;
    rpss_pkg::prof_state_t state_next;
    rpss_pkg::prof_state_t step_state;
    logic                  step_ok;
    logic                  step_done;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [rpss_pkg::SP_W-1:0]    out_sp_reg;
    logic [rpss_pkg::SP_W-1:0]    out_sp_next;
    logic [rpss_pkg::PHASE_W-1:0] out_phase_reg;
    logic [rpss_pkg::PHASE_W-1:0] out_phase_next;
    logic                  out_ok_reg;
    logic                  out_ok_next;
    logic                  out_done_reg;
    logic                  out_done_next;
    logic                  advance;
    logic                  s_accept;

    assign cfg_ready = 1'b1;

    rpss_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (cfg_valid),
        .wr_addr (cfg_addr),
        .wr_data (cfg_data),
        .cfg     (cfg)
    );

    rpss_step u_step (
        .cfg       (cfg),
        .cur       (state_reg),
        .item      (in_item_reg),
        .nxt       (step_state),
        .sample_ok (step_ok),
        .done      (step_done)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next  = in_valid_reg;
        in_item_next   = in_item_reg;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_sp_next    = out_sp_reg;
        out_phase_next = out_phase_reg;
        out_ok_next    = out_ok_reg;
        out_done_next  = out_done_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (advance) begin
            in_valid_next  = 1'b0;
            state_next     = step_state;
            out_valid_next = 1'b1;
            out_sp_next    = step_state.setpoint;
            out_phase_next = step_state.phase;
            out_ok_next    = step_ok;
            out_done_next  = step_done;
        end
        if (s_accept) begin
            in_valid_next         = 1'b1;
            in_item_next.temp_sample = s_tdata[11:0];
            in_item_next.start_req   = s_tdata[12];
            in_item_next.abort       = s_tdata[13];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= '0;
        end else begin
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
            state_reg      <= state_next;
        end
        in_item_reg   <= in_item_next;
        out_sp_reg    <= out_sp_next;
        out_phase_reg <= out_phase_next;
        out_ok_reg    <= out_ok_next;
        out_done_reg  <= out_done_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_ok_reg, out_phase_reg, out_sp_reg};
    assign m_tlast  = out_done_reg;

endmodule

[rtl/rpss_checker.sv]
module rpss_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    // A finished profile always lands in idle with the heater target cleared.
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[18:16] == rpss_pkg::PH_IDLE && m_tdata[15:0] == '0)
        else $error("done item not reported in idle with zero setpoint");

    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[18:16] == rpss_pkg::PH_IDLE |-> m_tdata[15:0] == '0)
        else $error("idle item carries a nonzero setpoint");

    a_done_needs_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[19])
        else $error("profile finished on a rejected sample");

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[18:16] != 3'd6 && m_tdata[18:16] != 3'd7)
        else $error("phase out of range");

    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result item changed");

endmodule

bind reflow_profile_setpoint_sequencer rpss_checker u_rpss_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
